// ===== src/aging_address_pool_assert.svh =====
// Assertion macros for the address pool checker.
`ifndef AGING_ADDRESS_POOL_ASSERT_SVH
`define AGING_ADDRESS_POOL_ASSERT_SVH

// Checked outside reset.
`define AAP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("address pool check failed");

// Checked during reset as well.
`define AAP_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("address pool reset check failed");

`endif

// ===== src/aap_pkg.sv =====
`default_nettype none
package aap_pkg;

   localparam int unsigned RAND_W    = 32;
   localparam int unsigned DIV_CNT_W = 6;

   localparam logic [1:0] FUNC_ADD  = 2'd0;
   localparam logic [1:0] FUNC_GEN  = 2'd1;
   localparam logic [1:0] FUNC_PICK = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [15:0] port;
      logic [31:0] now_sec;
      logic [19:0] now_usec;
      logic [31:0] rand_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        pick_valid;
      logic [63:0] pick_addr_hi;
      logic [63:0] pick_addr_lo;
      logic [15:0] pick_port;
      logic [4:0]  pool_size;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key_hi;
      logic [63:0] key_lo;
      logic [15:0] port;
      logic [32:0] exp_sec;
      logic [19:0] exp_usec;
      logic [31:0] gen;
   } entry_type;

   typedef enum logic [1:0] {RD_IDX, RD_LAST, RD_REM} rd_sel_type;
   typedef enum logic [1:0] {WR_NONE, WR_REFRESH, WR_APPEND, WR_MOVE} wr_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ADD_RD, ST_ADD_CMP, ST_PR_RD, ST_PR_CHK, ST_PR_MOV, ST_DIV, ST_DONE
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       idx_clr;
      logic       idx_inc;
      logic       rd_en;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      logic       gen_inc;
      logic       div_start;
      logic       div_step;
      logic       rsp_load;
      logic [1:0] rsp_status;
      logic       rsp_pick;
   } cmd_type;

   typedef struct packed {
      logic at_end;
      logic hit;
      logic survive;
      logic full;
      logic empty;
      logic div_done;
      logic rsp_free;
      logic is_pick;
   } sts_type;

endpackage
`default_nettype wire

// ===== src/aap_ctrl.sv =====
`default_nettype none
module aap_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [1:0]      req_func,
   output logic                 req_stall,
   input  wire aap_pkg::sts_type sts,
   output aap_pkg::cmd_type     cmd
);
   import aap_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] res_status_ff, res_status_in;
   logic       res_pick_ff, res_pick_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         res_status_ff <= STATUS_OK;
         res_pick_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         res_status_ff <= res_status_in;
         res_pick_ff   <= res_pick_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      res_status_in  = res_status_ff;
      res_pick_in    = res_pick_ff;
      cmd            = '0;
      cmd.rd_sel     = RD_IDX;
      cmd.wr_sel     = WR_NONE;
      cmd.rsp_status = res_status_ff;
      cmd.rsp_pick   = res_pick_ff;
      req_stall      = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req  = 1'b1;
               cmd.idx_clr   = 1'b1;
               res_status_in = STATUS_OK;
               res_pick_in   = 1'b0;
               unique case (req_func)
                  FUNC_ADD:  state_in = ST_ADD_RD;
                  FUNC_GEN: begin
                     cmd.gen_inc = 1'b1;
                     state_in    = ST_PR_RD;
                  end
                  FUNC_PICK: state_in = ST_PR_RD;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_ADD_RD: begin
            if (sts.at_end) begin
               if (sts.full) begin
                  res_status_in = STATUS_FULL;
               end else begin
                  cmd.wr_sel = WR_APPEND;
               end
               state_in = ST_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_ADD_CMP;
            end
         end
         ST_ADD_CMP: begin
            if (sts.hit) begin
               cmd.wr_sel = WR_REFRESH;
               state_in   = ST_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_ADD_RD;
            end
         end
         ST_PR_RD: begin
            if (sts.at_end) begin
               if (!sts.is_pick) begin
                  state_in = ST_DONE;
               end else if (sts.empty) begin
                  res_status_in = STATUS_EMPTY;
                  state_in      = ST_DONE;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_PR_CHK;
            end
         end
         ST_PR_CHK: begin
            if (sts.survive) begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_PR_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LAST;
               state_in   = ST_PR_MOV;
            end
         end
         ST_PR_MOV: begin
            // last entry fills the hole; same slot is checked again
            cmd.wr_sel = WR_MOVE;
            state_in   = ST_PR_RD;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_REM;
               res_pick_in = 1'b1;
               state_in    = ST_DONE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== src/aap_dp.sv =====
`default_nettype none
module aap_dp #(
   parameter int unsigned POOL_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [31:0]      csr_write_data,
   input  wire aap_pkg::req_type req_data,
   output aap_pkg::rsp_type      rsp_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire aap_pkg::cmd_type cmd,
   output aap_pkg::sts_type      sts
);
   import aap_pkg::*;

   localparam int unsigned IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);

   entry_type             entry_mem_ff [POOL_DEPTH];
   entry_type             rd_data_ff;
   req_type               req_ff;
   logic [31:0]           ttl_ff;
   logic [31:0]           gen_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      idx_ff;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [RAND_W-1:0]     rand_sh_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [CNT_W-1:0]      last_idx;
   logic [IDX_W-1:0]      rd_addr, wr_addr;
   logic                  wr_en;
   entry_type             wr_data;
   logic [32:0]           life_sec;
   logic [31:0]           gen_prev;
   logic [CNT_W:0]        trial, trial_sub;
   logic [31:0]           cnt_ext;

   assign last_idx = cnt_ff - CNT_W'(1);
   assign life_sec = {1'b0, req_ff.now_sec} + {1'b0, ttl_ff};
   assign gen_prev = gen_ff - 32'd1;
   assign cnt_ext  = 32'(cnt_ff);

   // one restoring step of rand_value mod count
   assign trial     = {rem_ff, rand_sh_ff[RAND_W-1]};
   assign trial_sub = trial - {1'b0, cnt_ff};
   assign rem_in    = (trial >= {1'b0, cnt_ff}) ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];

   always_comb begin
      unique case (cmd.rd_sel)
         RD_IDX:  rd_addr = idx_ff[IDX_W-1:0];
         RD_LAST: rd_addr = last_idx[IDX_W-1:0];
         RD_REM:  rd_addr = rem_ff[IDX_W-1:0];
         default: rd_addr = idx_ff[IDX_W-1:0];
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = idx_ff[IDX_W-1:0];
      wr_data = rd_data_ff;
      unique case (cmd.wr_sel)
         WR_NONE: wr_en = 1'b0;
         WR_REFRESH: begin
            wr_data.exp_sec  = life_sec;
            wr_data.exp_usec = req_ff.now_usec;
            wr_data.gen      = gen_ff;
         end
         WR_APPEND: begin
            wr_addr          = cnt_ff[IDX_W-1:0];
            wr_data.key_hi   = req_ff.addr_hi;
            wr_data.key_lo   = req_ff.addr_lo;
            wr_data.port     = req_ff.port;
            wr_data.exp_sec  = life_sec;
            wr_data.exp_usec = req_ff.now_usec;
            wr_data.gen      = gen_ff;
         end
         WR_MOVE: wr_data = rd_data_ff;
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.div_start) begin
         rand_sh_ff <= req_ff.rand_value;
      end else if (cmd.div_step) begin
         rand_sh_ff <= {rand_sh_ff[RAND_W-2:0], 1'b0};
      end
      if (cmd.rsp_load) begin
         rsp_data_ff.status       <= cmd.rsp_status;
         rsp_data_ff.pick_valid   <= cmd.rsp_pick;
         rsp_data_ff.pick_addr_hi <= cmd.rsp_pick ? rd_data_ff.key_hi : 64'd0;
         rsp_data_ff.pick_addr_lo <= cmd.rsp_pick ? rd_data_ff.key_lo : 64'd0;
         rsp_data_ff.pick_port    <= cmd.rsp_pick ? rd_data_ff.port : 16'd0;
         rsp_data_ff.pool_size    <= cnt_ext[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff       <= 32'd0;
         gen_ff       <= 32'd0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rem_ff       <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            ttl_ff <= csr_write_data;
         end
         if (cmd.gen_inc) begin
            gen_ff <= gen_ff + 32'd1;
         end
         if (cmd.wr_sel == WR_APPEND) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (cmd.wr_sel == WR_MOVE) begin
            cnt_ff <= last_idx;
         end
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         if (cmd.div_start) begin
            rem_ff     <= '0;
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            rem_ff     <= rem_in;
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.at_end   = (idx_ff >= cnt_ff);
      sts.hit      = (rd_data_ff.key_hi == req_ff.addr_hi) &&
                     (rd_data_ff.key_lo == req_ff.addr_lo) &&
                     (rd_data_ff.port == req_ff.port);
      sts.survive  = (rd_data_ff.gen == gen_ff) || (rd_data_ff.gen == gen_prev) ||
                     (rd_data_ff.exp_sec > {1'b0, req_ff.now_sec}) ||
                     ((rd_data_ff.exp_sec == {1'b0, req_ff.now_sec}) &&
                      (rd_data_ff.exp_usec > req_ff.now_usec));
      sts.full     = (cnt_ff == CNT_W'(POOL_DEPTH));
      sts.empty    = (cnt_ff == '0);
      sts.div_done = (div_cnt_ff == DIV_CNT_W'(RAND_W));
      sts.rsp_free = !rsp_valid_ff || !rsp_stall;
      sts.is_pick  = (req_ff.func == FUNC_PICK);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== src/aging_address_pool.sv =====
// Aging address pool: a table of up to POOL_DEPTH server addresses (128-bit
// address plus port), each with an expiry time and a generation.
// Request channel (req_valid / req_stall / req_data): one transaction is one
// command: add/refresh an address, end a generation and prune, or prune and
// pick an entry by rand_value mod pool size. Response channel (rsp_valid /
// rsp_stall / rsp_data): exactly one transaction per request, in order.
// csr_write_enable / csr_write_data load the TTL in seconds; write it only
// while the block is idle.
// Each entry visit is a memory read followed by a check of the entry read;
// prune moves the last entry into the place of each removed one, and pick
// then runs a bit-serial modulo. One command is worked at a time.
// The response sits in an output register: a stalled response does not block
// acceptance of the next request, which is worked until its own result is
// ready, then waits for the register to drain.
// Reset (synchronous, active high) empties the table, zeroes the generation
// and TTL, and drops any pending response. No clearing pass is needed.
`default_nettype none
module aging_address_pool #(
   parameter int unsigned POOL_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [31:0]      csr_write_data,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire aap_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output aap_pkg::rsp_type      rsp_data
);
   import aap_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: walks the table one entry at a time
   aap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // entry memory, counters, modulo unit and response register
   aap_dp #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule
`default_nettype wire

// ===== src/aap_checker.sv =====
`default_nettype none
`include "aging_address_pool_assert.svh"
module aap_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire aap_pkg::rsp_type rsp_data
);
   import aap_pkg::*;

   `AAP_ASSERT_RST(a_rsp_clear_after_reset, reset |=> !rsp_valid)
   `AAP_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid)
   `AAP_ASSERT(a_busy_after_accept, req_valid && !req_stall |=> req_stall)
   `AAP_ASSERT(a_pick_ok, rsp_valid && rsp_data.pick_valid |-> rsp_data.status == STATUS_OK)
   `AAP_ASSERT(a_empty_size, rsp_valid && rsp_data.status == STATUS_EMPTY |-> rsp_data.pool_size == 5'd0)

endmodule

bind aging_address_pool aap_checker u_aap_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ===== sim/aging_address_pool_tb.sv =====
`default_nettype none
module aging_address_pool_tb;
   import aap_pkg::*;

   localparam int unsigned DEPTH = 16;
   localparam logic [1:0] FUNC_NOP = 2'd3;   // unused code, changes nothing
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned DRAIN_CYCLES = 120;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;

   aging_address_pool #(.POOL_DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Shadow of the pool table, kept in step with each accepted transaction.
   logic [63:0] pool_hi   [DEPTH];
   logic [63:0] pool_lo   [DEPTH];
   logic [15:0] pool_port [DEPTH];
   logic [32:0] pool_esec [DEPTH];
   logic [19:0] pool_eusec[DEPTH];
   logic [31:0] pool_gen  [DEPTH];
   int unsigned pool_count;
   logic [31:0] generation;
   logic [31:0] ttl;

   rsp_type     pending_rsp[$];
   int unsigned error_count;
   int unsigned cycle_count;
   bit          rx_hold;      // forces a long receiver stall
   int unsigned hold_cycles;

   function automatic bit alive(int unsigned i, logic [31:0] ns, logic [19:0] nus);
      if (pool_gen[i] == generation || pool_gen[i] == generation - 32'd1)
         return 1'b1;
      if (pool_esec[i] > {1'b0, ns})
         return 1'b1;
      return pool_esec[i] == {1'b0, ns} && pool_eusec[i] > nus;
   endfunction

   // Drop stale entries; the last entry fills the hole and is rechecked.
   function automatic void prune_pool(logic [31:0] ns, logic [19:0] nus);
      int unsigned i;
      int unsigned last;
      i = 0;
      while (i < pool_count) begin
         if (alive(i, ns, nus)) begin
            i++;
         end else begin
            last = pool_count - 1;
            pool_hi[i]    = pool_hi[last];
            pool_lo[i]    = pool_lo[last];
            pool_port[i]  = pool_port[last];
            pool_esec[i]  = pool_esec[last];
            pool_eusec[i] = pool_eusec[last];
            pool_gen[i]   = pool_gen[last];
            pool_count    = last;
         end
      end
   endfunction

   function automatic rsp_type pool_response(req_type r);
      rsp_type     o;
      bit          hit;
      int unsigned i;
      int unsigned slot;
      o = '0;
      hit = 1'b0;
      slot = pool_count;
      case (r.func)
         FUNC_ADD: begin
            for (i = 0; i < pool_count; i++) begin
               if (!hit && pool_hi[i] == r.addr_hi && pool_lo[i] == r.addr_lo &&
                   pool_port[i] == r.port) begin
                  hit = 1'b1;
                  slot = i;
               end
            end
            if (!hit && pool_count >= DEPTH) begin
               o.status = STATUS_FULL;
            end else begin
               if (!hit) begin
                  pool_hi[slot]   = r.addr_hi;
                  pool_lo[slot]   = r.addr_lo;
                  pool_port[slot] = r.port;
                  pool_count++;
               end
               pool_esec[slot]  = {1'b0, r.now_sec} + {1'b0, ttl};
               pool_eusec[slot] = r.now_usec;
               pool_gen[slot]   = generation;
            end
         end
         FUNC_GEN: begin
            generation = generation + 32'd1;
            prune_pool(r.now_sec, r.now_usec);
         end
         FUNC_PICK: begin
            prune_pool(r.now_sec, r.now_usec);
            if (pool_count == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               slot = r.rand_value % pool_count;
               o.pick_valid   = 1'b1;
               o.pick_addr_hi = pool_hi[slot];
               o.pick_addr_lo = pool_lo[slot];
               o.pick_port    = pool_port[slot];
            end
         end
         default: ;
      endcase
      o.pool_size = pool_count[4:0];
      return o;
   endfunction

   // Sender: one transaction, held until accepted.
   task automatic send_req(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_rsp.push_back(pool_response(r));
   endtask

   // Burst pacing: occasional random gaps between transactions.
   int unsigned burst_left;
   task automatic send_paced(req_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_req(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_ttl(logic [31:0] v);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ttl = v;
   endtask

   // Small key space so that refreshes, hits and a full table are common.
   function automatic req_type rand_req(logic [1:0] f, logic [31:0] ns);
      req_type r;
      int unsigned k;
      r.func       = f;
      k            = $urandom_range(0, 23);
      r.addr_hi    = (k < 20) ? {48'h0, 16'(k >> 2)} : {$urandom, $urandom};
      r.addr_lo    = (k < 20) ? {62'h0, 2'(k)} : {$urandom, $urandom};
      r.port       = (k < 20) ? 16'(k % 3) : 16'($urandom);
      r.now_sec    = ns;
      r.now_usec   = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 999999));
      r.rand_value = $urandom;
      return r;
   endfunction

   function automatic req_type make_req(logic [1:0] f, logic [63:0] hi, logic [63:0] lo,
                                        logic [15:0] p, logic [31:0] ns, logic [19:0] nus,
                                        logic [31:0] rv);
      req_type r;
      r.func = f; r.addr_hi = hi; r.addr_lo = lo; r.port = p;
      r.now_sec = ns; r.now_usec = nus; r.rand_value = rv;
      return r;
   endfunction

   task automatic test_directed();
      int unsigned i;
      write_ttl(32'd5);
      send_req(make_req(FUNC_PICK, '0, '0, '0, 32'd0, 20'd0, '1));          // empty pool
      send_req(make_req(FUNC_ADD, '1, '1, '1, 32'd10, 20'd999999, 32'd0));
      send_req(make_req(FUNC_ADD, '0, '0, '0, 32'd10, 20'hFFFFF, 32'd0));  // usec above range
      send_req(make_req(FUNC_ADD, '1, '1, '1, 32'd12, 20'd3, 32'd0));      // refresh
      send_req(make_req(FUNC_NOP, '1, '1, '1, '1, '1, '1));
      send_req(make_req(FUNC_PICK, '0, '0, '0, 32'd0, 20'd0, '1));
      for (i = 0; i < 16; i++)
         send_req(make_req(FUNC_ADD, 64'(i) << 60, 64'(i), 16'(i), 32'd3, 20'd0, 32'd0));
      send_req(make_req(FUNC_ADD, 64'h55, 64'hAA, 16'h1, 32'd3, 20'd0, 32'd0)); // full
      send_req(make_req(FUNC_GEN, '0, '0, '0, 32'd17, 20'd5, '0));
      send_req(make_req(FUNC_GEN, '0, '0, '0, 32'd17, 20'd5, '0));          // stale entries go
      send_req(make_req(FUNC_PICK, '0, '0, '0, '1, '1, 32'd7));
   endtask

   // Expiry sums past 32 bits, repeated generations and a zero TTL.
   task automatic test_extremes();
      int unsigned i;
      write_ttl(32'hFFFF_FFFF);
      send_req(make_req(FUNC_ADD, 64'h1, 64'h2, 16'h3, 32'hFFFF_FFF0, 20'd1, '0));
      for (i = 0; i < 4; i++)
         send_req(make_req(FUNC_GEN, '0, '0, '0, 32'hFFFF_FFFF, 20'd0, '0));
      send_req(make_req(FUNC_PICK, '0, '0, '0, 32'hFFFF_FFFF, 20'd0, '1));
      write_ttl(32'd0);
      send_req(make_req(FUNC_ADD, 64'h9, 64'h9, 16'h9, 32'd100, 20'd50, '0));
      send_req(make_req(FUNC_GEN, '0, '0, '0, 32'd100, 20'd50, '0));
      send_req(make_req(FUNC_GEN, '0, '0, '0, 32'd100, 20'd49, '0));
      send_req(make_req(FUNC_GEN, '0, '0, '0, 32'd100, 20'd50, '0));     // expiry equal: removed
      send_req(make_req(FUNC_PICK, '0, '0, '0, 32'd100, 20'd50, '0));
   endtask

   // Random traffic with a slowly rising clock and frequent generations.
   task automatic test_random(int unsigned n, logic [31:0] ttl_val);
      int unsigned i;
      int unsigned pick;
      logic [31:0] ns;
      write_ttl(ttl_val);
      ns = $urandom_range(0, 1000);
      if ($urandom_range(0, 3) == 0) ns = 32'hFFFF_FF00;
      for (i = 0; i < n; i++) begin
         ns = ns + (($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 4)) : 32'd0);
         pick = $urandom_range(0, 99);
         if (pick < 55)
            send_paced(rand_req(FUNC_ADD, ns));
         else if (pick < 70)
            send_paced(rand_req(FUNC_GEN, ns));
         else if (pick < 97)
            send_paced(rand_req(FUNC_PICK, ns));
         else
            send_paced(rand_req(FUNC_NOP, ns));
      end
   endtask

   // Receiver holds off for a long stretch while requests keep arriving.
   task automatic test_backpressure();
      int unsigned i;
      hold_cycles = 400;
      rx_hold = 1'b1;
      for (i = 0; i < 12; i++)
         send_req(rand_req(FUNC_ADD, 32'd50));
      for (i = 0; i < 6; i++)
         send_req(rand_req(FUNC_PICK, 32'd50));
      wait_drained();
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_data         = '0;
      generation       = '0;
      pool_count       = 0;
      ttl              = '0;
      error_count      = 0;
      burst_left       = 0;
      rx_hold          = 1'b0;
      hold_cycles      = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_extremes();
      test_backpressure();
      test_random(400, 32'd3);
      test_random(400, 32'd0);
      test_random(400, 32'hFFFF_FFFF);
      test_random(450, $urandom_range(1, 20));
      wait_drained();
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Receiver stall pattern; a forced hold counts down in this process.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rx_hold) begin
         rsp_stall <= 1'b1;
         if (hold_cycles == 0) rx_hold <= 1'b0;
         else hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= (cycle_count[9:7] == 3'd5) ? 1'b0 : ($urandom_range(0, 3) == 0);
      end
   end
   initial rsp_stall = 1'b0;

   // Response checker: each accepted transaction against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected response %h", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.pick_valid !== want.pick_valid ||
                rsp_data.pick_addr_hi !== want.pick_addr_hi ||
                rsp_data.pick_addr_lo !== want.pick_addr_lo ||
                rsp_data.pick_port !== want.pick_port ||
                rsp_data.pool_size !== want.pool_size) begin
               $display("%0t mismatch expected %h actual %h", $time, want, rsp_data);
               error_count++;
            end
         end
      end
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule
`default_nettype wire
